FILE: rtl/asc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package asc_pkg;

   localparam int P_W    = 21;  // point coordinate port width
   localparam int DIR_W  = 21;  // one packed vector component
   localparam int CFG_W  = 63;  // widest register
   localparam int RAD_W  = 21;
   localparam int ANG_W  = 16;
   localparam int C_W    = 27;  // centred, projected coordinate
   localparam int Q_W    = 24;  // rounded cross product component
   localparam int D2_W   = 52;  // squared distance
   localparam int XY_W   = 56;  // angle unit x and y
   localparam int Z_W    = 27;  // angle accumulator, 1/65536 degree
   localparam int ROOT_W = 26;  // integer square root of the squared distance
   localparam int SIG_W  = 17;
   localparam int NUM_W  = 42;  // radial numerator scaled by 2^16
   localparam int IDX_W  = 3;

   localparam logic [SIG_W-1:0] SIGMA_ONE = SIG_W'(65536);
   localparam logic signed [Z_W-1:0] QUARTER_TURN = Z_W'(90 * 65536);

   localparam logic [CFG_W-1:0] AXIS_DIR_RST   = CFG_W'(524288);
   localparam logic [CFG_W-1:0] ZERO_DIR_RST   = {1'b0, 2'b10, 60'd0};
   localparam logic [RAD_W-1:0] RADIUS_OUT_RST = RAD_W'(1024);
   localparam logic signed [ANG_W-1:0] ANGLE_START_RST = -16'sd11520;
   localparam logic signed [ANG_W-1:0] ANGLE_END_RST   = 16'sd11520;

   typedef enum logic [IDX_W-1:0] {
      CSR_AXIS_DIR, CSR_ZERO_DIR, CSR_CENTRE, CSR_RADIUS_IN,
      CSR_RADIUS_OUT, CSR_ANGLE_START, CSR_ANGLE_END
   } csr_index_type;

   typedef struct packed {
      logic [CFG_W-1:0] axis_dir;
      logic [CFG_W-1:0] zero_dir;
      logic [CFG_W-1:0] centre;
   } asc_cfg_type;

   // atan(2^-i) in 1/65536 degree.
   function automatic logic signed [Z_W-1:0] cordic_atan(input int i);
      logic signed [Z_W-1:0] r;
      case (i)
         0: r = 27'sd2949120;  1: r = 27'sd1740967;  2: r = 27'sd919879;
         3: r = 27'sd466945;   4: r = 27'sd234379;   5: r = 27'sd117304;
         6: r = 27'sd58666;    7: r = 27'sd29335;    8: r = 27'sd14668;
         9: r = 27'sd7334;    10: r = 27'sd3667;    11: r = 27'sd1833;
         12: r = 27'sd917;    13: r = 27'sd458;     14: r = 27'sd229;
         15: r = 27'sd115;    16: r = 27'sd57;      17: r = 27'sd29;
         18: r = 27'sd14;     19: r = 27'sd7;       20: r = 27'sd4;
         21: r = 27'sd2;      22: r = 27'sd1;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/asc_front.sv
`timescale 1ns / 1ps
`default_nettype none
module asc_front import asc_pkg::*; #(
   parameter int COORD_WIDTH = 21
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    adv,
   input  wire asc_cfg_type             cfg,
   input  wire logic                    in_valid,
   input  wire logic [P_W-1:0]          in_x,
   input  wire logic [P_W-1:0]          in_y,
   input  wire logic [P_W-1:0]          in_z,
   output logic                         out_valid,
   output logic signed [XY_W-1:0]       out_x,
   output logic signed [XY_W-1:0]       out_y,
   output logic signed [Z_W-1:0]        out_z,
   output logic                         out_zero,
   output logic [D2_W-1:0]              out_d2
);
   localparam int SH = P_W - COORD_WIDTH;

   logic signed [DIR_W-1:0] a [3];
   logic signed [DIR_W-1:0] z0 [3];
   logic signed [DIR_W-1:0] ce [3];
   logic [P_W-1:0]          raw [3];
   logic signed [P_W-1:0]   p [3];

   logic signed [Q_W-1:0] q_ff [3];
   logic signed [Q_W-1:0] q_in [3];

   logic                    v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff;
   logic signed [P_W-1:0]   p1_ff [3], p2_ff [3], p3_ff [3];
   logic signed [41:0]      m1_ff [3], m1_in [3];
   logic signed [43:0]      dot2_ff, dot2_in;
   logic signed [42:0]      mh3_ff [3], mh3_in [3];
   logic signed [43:0]      ml3_ff [3], ml3_in [3];
   logic signed [C_W-1:0]   c4_ff [3], c4_in [3];
   logic signed [53:0]      sq5_ff [3], sq5_in [3];
   logic signed [50:0]      yq5_ff [3], yq5_in [3];
   logic signed [47:0]      xz5_ff [3], xz5_in [3];
   logic [D2_W-1:0]         d2_6_ff, d2_6_in, d2_7_ff;
   logic signed [XY_W-1:0]  x6_ff, x6_in, y6_ff, y6_in;
   logic signed [XY_W-1:0]  x7_ff, x7_in, y7_ff, y7_in;
   logic signed [Z_W-1:0]   z7_ff, z7_in;
   logic                    zero7_ff, zero7_in;

   assign raw[0] = in_x;
   assign raw[1] = in_y;
   assign raw[2] = in_z;

   always_comb begin
      logic signed [42:0] dif;
      logic signed [65:0] full;
      logic signed [65:0] proj;
      logic [P_W-1:0]     t;
      for (int i = 0; i < 3; i++) begin
         a[i]  = cfg.axis_dir[CFG_W-1-DIR_W*i -: DIR_W];
         z0[i] = cfg.zero_dir[CFG_W-1-DIR_W*i -: DIR_W];
         ce[i] = cfg.centre[CFG_W-1-DIR_W*i -: DIR_W];
         t     = raw[i] << SH;
         p[i]  = $signed(t) >>> SH;
         m1_in[i] = a[i] * p[i];
      end
      // q = zero_dir x axis_dir, rounded to Q.19.
      for (int i = 0; i < 3; i++) begin
         dif = 43'(z0[(i+1)%3] * a[(i+2)%3]) - 43'(z0[(i+2)%3] * a[(i+1)%3]);
         dif = dif + (43'sd1 <<< 18);
         q_in[i] = Q_W'(dif >>> 19);
      end
      dot2_in = 44'(m1_ff[0]) + 44'(m1_ff[1]) + 44'(m1_ff[2]);
      for (int i = 0; i < 3; i++) begin
         // dot * a is split into high and low halves of dot.
         mh3_in[i] = $signed(dot2_ff[43:22]) * a[i];
         ml3_in[i] = $signed({1'b0, dot2_ff[21:0]}) * a[i];
         full = (66'(mh3_ff[i]) <<< 22) + 66'(ml3_ff[i]) + (66'sd1 <<< 37);
         proj = full >>> 38;
         c4_in[i] = C_W'(p3_ff[i]) - C_W'(proj) - C_W'(ce[i]);
         sq5_in[i] = c4_ff[i] * c4_ff[i];
         yq5_in[i] = c4_ff[i] * q_ff[i];
         xz5_in[i] = c4_ff[i] * z0[i];
      end
      d2_6_in = D2_W'(sq5_ff[0]) + D2_W'(sq5_ff[1]) + D2_W'(sq5_ff[2]);
      x6_in = XY_W'(xz5_ff[0]) + XY_W'(xz5_ff[1]) + XY_W'(xz5_ff[2]);
      y6_in = XY_W'(yq5_ff[0]) + XY_W'(yq5_ff[1]) + XY_W'(yq5_ff[2]);
      // Left half plane: turn by a quarter first so the unit converges.
      zero7_in = (x6_ff == '0) && (y6_ff == '0);
      x7_in = x6_ff;
      y7_in = y6_ff;
      z7_in = '0;
      if (x6_ff < 0) begin
         if (y6_ff >= 0) begin
            x7_in = y6_ff;
            y7_in = -x6_ff;
            z7_in = QUARTER_TURN;
         end else begin
            x7_in = -y6_ff;
            y7_in = x6_ff;
            z7_in = -QUARTER_TURN;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0; v4_ff <= 1'b0;
         v5_ff <= 1'b0; v6_ff <= 1'b0; v7_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid; v2_ff <= v1_ff; v3_ff <= v2_ff; v4_ff <= v3_ff;
         v5_ff <= v4_ff; v6_ff <= v5_ff; v7_ff <= v6_ff;
      end
      if (adv) begin
         p1_ff  <= p;
         m1_ff  <= m1_in;
         p2_ff  <= p1_ff;
         dot2_ff <= dot2_in;
         p3_ff  <= p2_ff;
         mh3_ff <= mh3_in;
         ml3_ff <= ml3_in;
         c4_ff  <= c4_in;
         sq5_ff <= sq5_in;
         yq5_ff <= yq5_in;
         xz5_ff <= xz5_in;
         d2_6_ff <= d2_6_in;
         x6_ff  <= x6_in;
         y6_ff  <= y6_in;
         d2_7_ff <= d2_6_ff;
         x7_ff  <= x7_in;
         y7_ff  <= y7_in;
         z7_ff  <= z7_in;
         zero7_ff <= zero7_in;
      end
   end

   assign out_valid = v7_ff;
   assign out_x     = x7_ff;
   assign out_y     = y7_ff;
   assign out_z     = z7_ff;
   assign out_zero  = zero7_ff;
   assign out_d2    = d2_7_ff;
endmodule
`default_nettype wire

FILE: rtl/asc_cordic_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module asc_cordic_cell import asc_pkg::*; #(
   parameter int STAGE  = 0,
   parameter int SIDE_W = 1
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   adv,
   input  wire logic                   in_valid,
   input  wire logic signed [XY_W-1:0] in_x,
   input  wire logic signed [XY_W-1:0] in_y,
   input  wire logic signed [Z_W-1:0]  in_z,
   input  wire logic [SIDE_W-1:0]      in_side,
   output logic                        out_valid,
   output logic signed [XY_W-1:0]      out_x,
   output logic signed [XY_W-1:0]      out_y,
   output logic signed [Z_W-1:0]       out_z,
   output logic [SIDE_W-1:0]           out_side
);
   logic                   valid_ff;
   logic signed [XY_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [Z_W-1:0]  z_ff, z_in;
   logic [SIDE_W-1:0]      side_ff;

   always_comb begin
      logic signed [XY_W-1:0] dx, dy;
      dx = in_y >>> STAGE;
      dy = in_x >>> STAGE;
      if (in_y >= 0) begin
         x_in = in_x + dx;
         y_in = in_y - dy;
         z_in = in_z + cordic_atan(STAGE);
      end else begin
         x_in = in_x - dx;
         y_in = in_y + dy;
         z_in = in_z - cordic_atan(STAGE);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
      if (adv) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;
   assign out_side  = side_ff;
endmodule
`default_nettype wire

FILE: rtl/asc_sqrt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module asc_sqrt_cell import asc_pkg::*; #(
   parameter int BIT    = 0,
   parameter int SIDE_W = 1
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                adv,
   input  wire logic                in_valid,
   input  wire logic [D2_W-1:0]     in_rem,
   input  wire logic [ROOT_W-1:0]   in_root,
   input  wire logic [SIDE_W-1:0]   in_side,
   output logic                     out_valid,
   output logic [D2_W-1:0]          out_rem,
   output logic [ROOT_W-1:0]        out_root,
   output logic [SIDE_W-1:0]        out_side
);
   logic                valid_ff;
   logic [D2_W-1:0]     rem_ff, rem_in;
   logic [ROOT_W-1:0]   root_ff, root_in;
   logic [SIDE_W-1:0]   side_ff;

   // Remainder holds n - root^2; trying this bit adds root*2^(BIT+1) + 4^BIT.
   always_comb begin
      logic [D2_W+1:0] delta;
      delta = ((D2_W+2)'(in_root) << (BIT + 1)) + ((D2_W+2)'(1) << (2 * BIT));
      rem_in  = in_rem;
      root_in = in_root;
      if ((D2_W+2)'(in_rem) >= delta) begin
         rem_in  = in_rem - D2_W'(delta);
         root_in = in_root | (ROOT_W'(1) << BIT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
      if (adv) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;
   assign out_side  = side_ff;
endmodule
`default_nettype wire

FILE: rtl/asc_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module asc_div_cell import asc_pkg::*; #(
   parameter int BIT    = 0,
   parameter int SIDE_W = 1
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                adv,
   input  wire logic                in_valid,
   input  wire logic [RAD_W-1:0]    divisor,
   input  wire logic [NUM_W-1:0]    in_rem,
   input  wire logic [SIG_W-1:0]    in_quo,
   input  wire logic [SIDE_W-1:0]   in_side,
   output logic                     out_valid,
   output logic [NUM_W-1:0]         out_rem,
   output logic [SIG_W-1:0]         out_quo,
   output logic [SIDE_W-1:0]        out_side
);
   logic               valid_ff;
   logic [NUM_W-1:0]   rem_ff, rem_in;
   logic [SIG_W-1:0]   quo_ff, quo_in;
   logic [SIDE_W-1:0]  side_ff;

   always_comb begin
      logic [NUM_W-1:0] sub;
      sub    = NUM_W'(divisor) << BIT;
      rem_in = in_rem;
      quo_in = in_quo;
      if (in_rem >= sub) begin
         rem_in = in_rem - sub;
         quo_in = in_quo | (SIG_W'(1) << BIT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
      if (adv) begin
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_quo   = quo_ff;
   assign out_side  = side_ff;
endmodule
`default_nettype wire

FILE: rtl/annular_sector_point_classifier.sv
`timescale 1ns / 1ps
`default_nettype none
// Annular sector point classifier.
// Each item on the req_ channel is one 3-D point (Q11.10). The block drops the
// component along the axis, subtracts the sector centre and answers on the
// rsp_ channel whether the point lies between the two radii and inside the
// angle window, plus the normalized radial coordinate sigma (Q1.16).
// Exactly one result item leaves for each point, in order.
// Throughput is one item per cycle unless the output stalls. Stages in order:
// seven front stages of multipliers and sums, one cell per angle iteration,
// one compare stage, 26 square-root cells (one root bit each), one numerator
// stage, 17 divider cells (one quotient bit each) and the output register.
// The whole pipeline moves as one; it holds only when a result waits in the
// output register and rsp_ready is low, and then req_ready is low as well.
// Reset empties the pipeline and loads the register defaults: axis along z,
// zero angle along x, unit outer radius, window from -90 to +90 degrees.
// The csr_ port writes one register per cycle at the given index; indexes
// beyond the last register are ignored. The user must write only while the
// block is empty (not enforced); derived constants follow in the next cycle.
module annular_sector_point_classifier import asc_pkg::*; #(
   parameter int COORD_WIDTH   = 21,
   parameter int CORDIC_STAGES = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [P_W-1:0]     req_point_x,
   input  wire logic [P_W-1:0]     req_point_y,
   input  wire logic [P_W-1:0]     req_point_z,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_inside_res,
   output logic [SIG_W-1:0]        rsp_sigma,
   input  wire logic               csr_we,
   input  wire logic [IDX_W-1:0]   csr_index,
   input  wire logic [CFG_W-1:0]   csr_wdata
);
   localparam int CSIDE_W = D2_W + 1;

   // Configuration registers.
   logic [CFG_W-1:0]        axis_dir_ff, zero_dir_ff, centre_ff;
   logic [RAD_W-1:0]        radius_in_ff, radius_out_ff;
   logic signed [ANG_W-1:0] angle_start_ff, angle_end_ff;
   logic [2*RAD_W-1:0]      rin2_ff, rout2_ff;
   logic [RAD_W-1:0]        width_ff;
   asc_cfg_type             cfg;

   // The pipeline advances unless a finished result is held back.
   logic adv;

   // Angle cells.
   logic                   cv [CORDIC_STAGES+1];
   logic signed [XY_W-1:0] cx [CORDIC_STAGES+1];
   logic signed [XY_W-1:0] cy [CORDIC_STAGES+1];
   logic signed [Z_W-1:0]  cz [CORDIC_STAGES+1];
   logic [CSIDE_W-1:0]     cs [CORDIC_STAGES+1];
   logic                   front_zero;
   logic [D2_W-1:0]        front_d2;

   // Compare stage.
   logic                   va_ff, inside_a_ff, inside_a_in;
   logic [D2_W-1:0]        d2_a_ff;

   // Square-root cells.
   logic                   sv [ROOT_W+1];
   logic [D2_W-1:0]        srem [ROOT_W+1];
   logic [ROOT_W-1:0]      sroot [ROOT_W+1];
   logic                   sside [ROOT_W+1];

   // Numerator stage.
   logic                   vb_ff, inside_b_ff;
   logic [NUM_W-1:0]       num_b_ff, num_b_in;

   // Divider cells.
   logic                   dv [SIG_W+1];
   logic [NUM_W-1:0]       drem [SIG_W+1];
   logic [SIG_W-1:0]       dquo [SIG_W+1];
   logic                   dside [SIG_W+1];

   // Output register.
   logic                   rsp_valid_ff;
   logic                   rsp_inside_ff;
   logic [SIG_W-1:0]       rsp_sigma_ff, rsp_sigma_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_dir_ff    <= AXIS_DIR_RST;
         zero_dir_ff    <= ZERO_DIR_RST;
         centre_ff      <= '0;
         radius_in_ff   <= '0;
         radius_out_ff  <= RADIUS_OUT_RST;
         angle_start_ff <= ANGLE_START_RST;
         angle_end_ff   <= ANGLE_END_RST;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_AXIS_DIR:    axis_dir_ff    <= csr_wdata;
            CSR_ZERO_DIR:    zero_dir_ff    <= csr_wdata;
            CSR_CENTRE:      centre_ff      <= csr_wdata;
            CSR_RADIUS_IN:   radius_in_ff   <= csr_wdata[RAD_W-1:0];
            CSR_RADIUS_OUT:  radius_out_ff  <= csr_wdata[RAD_W-1:0];
            CSR_ANGLE_START: angle_start_ff <= csr_wdata[ANG_W-1:0];
            CSR_ANGLE_END:   angle_end_ff   <= csr_wdata[ANG_W-1:0];
            default: ;
         endcase
      end
   end

   // Constants that follow from the radii alone.
   always_ff @(posedge clock) begin
      rin2_ff  <= radius_in_ff * radius_in_ff;
      rout2_ff <= radius_out_ff * radius_out_ff;
      width_ff <= (radius_out_ff > radius_in_ff) ? radius_out_ff - radius_in_ff
                                                 : radius_in_ff - radius_out_ff;
   end

   assign cfg.axis_dir = axis_dir_ff;
   assign cfg.zero_dir = zero_dir_ff;
   assign cfg.centre   = centre_ff;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   asc_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .cfg       (cfg),
      .in_valid  (req_valid),
      .in_x      (req_point_x),
      .in_y      (req_point_y),
      .in_z      (req_point_z),
      .out_valid (cv[0]),
      .out_x     (cx[0]),
      .out_y     (cy[0]),
      .out_z     (cz[0]),
      .out_zero  (front_zero),
      .out_d2    (front_d2)
   );
   assign cs[0] = {front_zero, front_d2};

   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
      asc_cordic_cell #(.STAGE(g), .SIDE_W(CSIDE_W)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (cv[g]),
         .in_x      (cx[g]),
         .in_y      (cy[g]),
         .in_z      (cz[g]),
         .in_side   (cs[g]),
         .out_valid (cv[g+1]),
         .out_x     (cx[g+1]),
         .out_y     (cy[g+1]),
         .out_z     (cz[g+1]),
         .out_side  (cs[g+1])
      );
   end

   // Round the angle to 1/128 degree, then test the window and both radii.
   always_comb begin
      logic signed [Z_W-1:0] ang;
      logic signed [Z_W-1:0] as_w, ae_w;
      logic                  in_ang;
      logic [D2_W-1:0]       d2;
      d2   = cs[CORDIC_STAGES][D2_W-1:0];
      ang  = (cz[CORDIC_STAGES] + Z_W'(256)) >>> 9;
      if (cs[CORDIC_STAGES][D2_W]) begin
         ang = '0;
      end
      as_w = Z_W'(angle_start_ff);
      ae_w = Z_W'(angle_end_ff);
      if (as_w < ae_w) begin
         in_ang = (as_w <= ang) && (ang <= ae_w);
      end else begin
         in_ang = (as_w <= ang) || (ang <= ae_w);
      end
      inside_a_in = (d2 >= D2_W'(rin2_ff)) && (d2 <= D2_W'(rout2_ff)) && in_ang;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else if (adv) begin
         va_ff <= cv[CORDIC_STAGES];
      end
      if (adv) begin
         inside_a_ff <= inside_a_in;
         d2_a_ff     <= cs[CORDIC_STAGES][D2_W-1:0];
      end
   end

   assign sv[0]    = va_ff;
   assign srem[0]  = d2_a_ff;
   assign sroot[0] = '0;
   assign sside[0] = inside_a_ff;

   for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
      asc_sqrt_cell #(.BIT(ROOT_W - 1 - g), .SIDE_W(1)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (sv[g]),
         .in_rem    (srem[g]),
         .in_root   (sroot[g]),
         .in_side   (sside[g]),
         .out_valid (sv[g+1]),
         .out_rem   (srem[g+1]),
         .out_root  (sroot[g+1]),
         .out_side  (sside[g+1])
      );
   end

   // Numerator (dist - radius_inner), clamped at zero and scaled by 2^16.
   always_comb begin
      logic signed [ROOT_W+1:0] num;
      num = $signed({2'b00, sroot[ROOT_W]}) - $signed((ROOT_W+2)'(radius_in_ff));
      if (num < 0) begin
         num = '0;
      end
      num_b_in = NUM_W'(num[ROOT_W-1:0]) << 16;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
      end else if (adv) begin
         vb_ff <= sv[ROOT_W];
      end
      if (adv) begin
         inside_b_ff <= sside[ROOT_W];
         num_b_ff    <= num_b_in;
      end
   end

   assign dv[0]    = vb_ff;
   assign drem[0]  = num_b_ff;
   assign dquo[0]  = '0;
   assign dside[0] = inside_b_ff;

   for (genvar g = 0; g < SIG_W; g++) begin : g_div
      asc_div_cell #(.BIT(SIG_W - 1 - g), .SIDE_W(1)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (dv[g]),
         .divisor   (width_ff),
         .in_rem    (drem[g]),
         .in_quo    (dquo[g]),
         .in_side   (dside[g]),
         .out_valid (dv[g+1]),
         .out_rem   (drem[g+1]),
         .out_quo   (dquo[g+1]),
         .out_side  (dside[g+1])
      );
   end

   // Sigma is zero outside the sector and for a zero-width ring.
   always_comb begin
      rsp_sigma_in = '0;
      if (dside[SIG_W] && (width_ff != '0)) begin
         rsp_sigma_in = (dquo[SIG_W] > SIGMA_ONE) ? SIGMA_ONE : dquo[SIG_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dv[SIG_W];
      end
      if (adv) begin
         rsp_inside_ff <= dside[SIG_W];
         rsp_sigma_ff  <= rsp_sigma_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_inside_res = rsp_inside_ff;
   assign rsp_sigma      = rsp_sigma_ff;

   a_no_sigma_outside: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_inside_res |-> rsp_sigma == '0)
      else $error("sigma set for a point outside the sector");

   a_sigma_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_sigma <= SIGMA_ONE)
      else $error("sigma above one");

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken while the output is stalled");

   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result present right after reset");

   a_zero_width_sigma: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (radius_in_ff == radius_out_ff) && $stable(width_ff)
      |-> rsp_sigma == '0)
      else $error("sigma set for a zero-width ring");
endmodule
`default_nettype wire

FILE: dv/asc_checker.sv
`timescale 1ns / 1ps
module asc_checker import asc_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_ready,
   input  wire logic [P_W-1:0]   req_point_x,
   input  wire logic [P_W-1:0]   req_point_y,
   input  wire logic [P_W-1:0]   req_point_z,
   input  wire logic             rsp_valid,
   input  wire logic             rsp_ready,
   input  wire logic             rsp_inside_res,
   input  wire logic [SIG_W-1:0] rsp_sigma,
   input  wire logic             csr_we,
   input  wire logic [IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    pending
);

   localparam int STAGES = 16;

   typedef struct {
      logic             hit;
      logic [SIG_W-1:0] sigma;
   } verdict_type;

   // atan(2^-i) in 1/65536 degree.
   localparam longint ATAN_STEP [0:15] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115};

   logic [CFG_W-1:0] axis_q, zdir_q, centre_q;
   logic [RAD_W-1:0] rin_q, rout_q;
   logic [ANG_W-1:0] ang_start_q, ang_end_q;
   verdict_type      verdicts[$];

   function automatic longint comp(logic [CFG_W-1:0] r, int i);
      logic signed [DIR_W-1:0] f;
      f = r[CFG_W-1-DIR_W*i -: DIR_W];
      return longint'(f);
   endfunction

   function automatic longint unsigned int_root(longint unsigned n);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n = n - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   // Vectoring CORDIC, result in 1/128 degree.
   function automatic longint heading(longint x, longint y);
      longint z, t, dx, dy;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         if (y >= 0) begin
            t = x; x = y; y = -t; z = 90 * 65536;
         end else begin
            t = x; x = -y; y = t; z = -90 * 65536;
         end
      end
      for (int i = 0; i < STAGES; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x += dx; y -= dy; z += ATAN_STEP[i];
         end else begin
            x -= dx; y += dy; z -= ATAN_STEP[i];
         end
      end
      return (z + 256) >>> 9;
   endfunction

   function automatic verdict_type classify(logic [P_W-1:0] px, logic [P_W-1:0] py,
                                            logic [P_W-1:0] pz);
      longint p[3], a[3], w[3], ce[3], c[3], q[3];
      longint dot, xs, ys, ang, as, ae, rin, rout, span, num;
      longint unsigned d2;
      logic in_ang;
      verdict_type v;
      p[0] = longint'($signed(px));
      p[1] = longint'($signed(py));
      p[2] = longint'($signed(pz));
      for (int i = 0; i < 3; i++) begin
         a[i] = comp(axis_q, i);
         w[i] = comp(zdir_q, i);
         ce[i] = comp(centre_q, i);
      end
      dot = a[0] * p[0] + a[1] * p[1] + a[2] * p[2];
      d2 = 0;
      for (int i = 0; i < 3; i++) begin
         c[i] = p[i] - ((dot * a[i] + (64'sd1 <<< 37)) >>> 38) - ce[i];
         d2 += longint'(c[i] * c[i]);
      end
      q[0] = (w[1] * a[2] - w[2] * a[1] + (64'sd1 <<< 18)) >>> 19;
      q[1] = (w[2] * a[0] - w[0] * a[2] + (64'sd1 <<< 18)) >>> 19;
      q[2] = (w[0] * a[1] - w[1] * a[0] + (64'sd1 <<< 18)) >>> 19;
      ys = c[0] * q[0] + c[1] * q[1] + c[2] * q[2];
      xs = c[0] * w[0] + c[1] * w[1] + c[2] * w[2];
      ang = heading(xs, ys);
      as = longint'($signed(ang_start_q));
      ae = longint'($signed(ang_end_q));
      // A start at or past the end wraps through 180 degrees.
      if (as < ae) in_ang = (as <= ang) && (ang <= ae);
      else in_ang = (as <= ang) || (ang <= ae);
      rin = longint'(rin_q);
      rout = longint'(rout_q);
      v.hit = (d2 >= rin * rin) && (d2 <= rout * rout) && in_ang;
      v.sigma = '0;
      if (v.hit) begin
         span = (rout > rin) ? rout - rin : rin - rout;
         if (span != 0) begin
            num = longint'(int_root(d2)) - rin;
            if (num < 0) num = 0;
            num = (num * 65536) / span;
            if (num > 65536) num = 65536;
            v.sigma = SIG_W'(num);
         end
      end
      return v;
   endfunction

   assign pending = verdicts.size();

   always @(posedge clock) begin
      verdict_type e;
      if (reset) begin
         axis_q <= AXIS_DIR_RST;
         zdir_q <= ZERO_DIR_RST;
         centre_q <= '0;
         rin_q <= '0;
         rout_q <= RADIUS_OUT_RST;
         ang_start_q <= ANGLE_START_RST;
         ang_end_q <= ANGLE_END_RST;
         verdicts.delete();
         fail_count <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_AXIS_DIR:    axis_q <= csr_wdata;
               CSR_ZERO_DIR:    zdir_q <= csr_wdata;
               CSR_CENTRE:      centre_q <= csr_wdata;
               CSR_RADIUS_IN:   rin_q <= csr_wdata[RAD_W-1:0];
               CSR_RADIUS_OUT:  rout_q <= csr_wdata[RAD_W-1:0];
               CSR_ANGLE_START: ang_start_q <= csr_wdata[ANG_W-1:0];
               CSR_ANGLE_END:   ang_end_q <= csr_wdata[ANG_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            verdicts.push_back(classify(req_point_x, req_point_y, req_point_z));
         if (rsp_valid && rsp_ready) begin
            if (verdicts.size() == 0) begin
               $display("%0t: result with no point pending", $time);
               fail_count <= fail_count + 1;
            end else begin
               e = verdicts.pop_front();
               if (e.hit !== rsp_inside_res || e.sigma !== rsp_sigma) begin
                  $display("%0t: mismatch inside exp %0d act %0d, sigma exp %0d act %0d",
                           $time, e.hit, rsp_inside_res, e.sigma, rsp_sigma);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
module testbench import asc_pkg::*;;

   // Extra wait that covers the latency of the block.
   localparam int DRAIN = 90;
   localparam int CYCLE_LIMIT = 400000;
   localparam int ONE = 524288;     // 1.0 in Q1.19
   localparam int DIAG = 370728;    // about 0.7071 in Q1.19

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic [P_W-1:0]   req_point_x = '0, req_point_y = '0, req_point_z = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic             rsp_inside_res;
   logic [SIG_W-1:0] rsp_sigma;
   logic             csr_we = 1'b0;
   logic [IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0] csr_wdata = '0;
   int               fail_count, pending;
   int               idle_pct = 36;
   int               cycles = 0;
   int               span = 2048;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   annular_sector_point_classifier DUT (.*);

   asc_checker checker_i (.*);

   // The result side stalls at the same rate as the sender idles.
   always @(posedge clock) rsp_ready <= ($urandom_range(99) >= idle_pct);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic logic [CFG_W-1:0] vec(int x, int y, int z);
      return {DIR_W'(x), DIR_W'(y), DIR_W'(z)};
   endfunction

   function automatic logic [CFG_W-1:0] rand_vec();
      return CFG_W'({$urandom, $urandom});
   endfunction

   // Offers one point. Valid is only lowered when an idle gap is taken, so it
   // never gets two assignments in one step.
   task automatic send_point(int x, int y, int z);
      int gap;
      gap = 0;
      while ($urandom_range(99) < idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_point_x <= P_W'(x);
      req_point_y <= P_W'(y);
      req_point_z <= P_W'(z);
      do @(posedge clock); while (!req_ready);
   endtask

   // A coordinate either anywhere in the field or near the sector's scale.
   function automatic int coord();
      if ($urandom_range(99) < 35) return int'($signed(P_W'($urandom)));
      return $urandom_range(2 * span) - span;
   endfunction

   task automatic send_random(int n);
      for (int i = 0; i < n; i++) send_point(coord(), coord(), coord());
   endtask

   // Registers are written only once the pipeline has emptied.
   task automatic quiesce();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   task automatic write_all(logic [CFG_W-1:0] ax, logic [CFG_W-1:0] zd,
                            logic [CFG_W-1:0] ce, int rin, int rout,
                            int a0, int a1);
      logic [CFG_W-1:0] vals [0:7];
      vals = '{ax, zd, ce, CFG_W'(rin), CFG_W'(rout), CFG_W'(a0), CFG_W'(a1), rand_vec()};
      quiesce();
      for (int i = 0; i < 8; i++) begin
         csr_we <= 1'b1;
         csr_index <= IDX_W'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      @(posedge clock);
      span = (rout > rin ? rout : rin) * 3 / 2 + 64;
   endtask

   initial begin
      int rin, rout;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed points against the reset setup: unit disc, window -90..+90.
      send_point(0, 0, 0);            // no projection at all: angle is zero
      send_point(0, 0, 5000);         // lies on the axis only
      send_point(1024, 0, 0);         // exactly on the outer radius
      send_point(0, 1024, 0);         // bottom edge of the angle window
      send_point(0, -1024, 0);        // top edge of the angle window
      send_point(-512, 0, 0);         // behind the window
      send_point(-512, 1, 0);
      send_point(-512, -1, 0);
      send_point(1025, 0, 0);         // just outside the outer radius
      send_point(724, 724, 77);
      send_point(1048575, 1048575, 1048575);
      send_point(-1048576, -1048576, -1048576);
      send_point(1048575, -1048576, 0);
      send_point(-1048576, 1048575, 1048575);
      send_point(300, -200, -1048576);
      send_point(1, 0, 0);

      // Axis along x, a narrow window in the first quadrant.
      write_all(vec(ONE, 0, 0), vec(0, ONE, 0), vec(0, 37, -81), 512, 3000, 0, 11520);
      send_point(0, 3037, -81);       // on the outer radius and the window start
      send_point(0, 549, 431);        // near the inner radius
      send_random(170);

      // Window through 180 degrees and zero radial width: sigma stays zero.
      write_all(vec(0, 0, -ONE), vec(-ONE, 0, 0), '0, 2000, 2000, 17920, -17920);
      send_point(2000, 0, 9);
      send_random(170);

      // Equal start and end pass every angle; inner above outer passes nothing.
      write_all(vec(0, ONE, 0), vec(0, 0, ONE), vec(100, 0, -100), 4000, 1000, 640, 640);
      send_random(150);
      write_all(vec(0, ONE, 0), vec(0, 0, ONE), vec(100, 0, -100), 0, 6000, -3000, -3000);
      send_random(150);

      // Extremes: widest radii and window, arbitrary vectors and centre.
      write_all(rand_vec(), rand_vec(), rand_vec(), 0, 2097151, -23040, 23040);
      send_random(150);
      write_all(vec(-1048576, 1048575, -1048576), vec(1048575, -1048576, 1048575),
                vec(-1048576, -1048576, 1048575), 2097151, 0, 23040, -23040);
      send_random(120);

      // Diagonal unit vectors with fixed radii and window, full-rate stretch.
      idle_pct = 0;
      write_all(vec(DIAG, 0, DIAG), vec(DIAG, 0, -DIAG), vec(-300, 12, 300),
                700, 5200, -6000, 14000);
      send_random(200);
      idle_pct = 36;

      for (int k = 0; k < 3; k++) begin
         rin = $urandom_range(0, 4000);
         rout = rin + $urandom_range(0, 8000);
         write_all(vec(0, 0, ONE), vec(DIAG, DIAG, 0),
                   vec($urandom_range(4000) - 2000, $urandom_range(4000) - 2000, 0),
                   rin, rout, $urandom_range(46080) - 23040, $urandom_range(46080) - 23040);
         send_random(140);
      end

      quiesce();
      if (fail_count == 0 && pending == 0) begin
         $display("*** PASSED ***");
      end else begin
         if (pending != 0) $display("%0t: %0d results never arrived", $time, pending);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
